FILE: rtl/core/assert_macros.svh
// Assertion macros for the RTL files of the matcher.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge of clk, switched off while rst_n is low.
`define WBSM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Property checked on every rising edge of clk, reset included.
`define WBSM_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: rtl/core/wbsm_pkg.sv
// Package of shared types, constants and byte helpers for the matcher.
`timescale 1ns / 1ps

package wbsm_pkg;

    localparam logic [7:0] CHAR_SPACE     = 8'h20;
    localparam logic [7:0] CHAR_PERIOD    = 8'h2E;
    localparam logic [7:0] CHAR_COMMA     = 8'h2C;
    localparam logic [7:0] CHAR_SEMICOLON = 8'h3B;
    localparam logic [7:0] CHAR_QUESTION  = 8'h3F;
    localparam logic [7:0] CHAR_EXCLAIM   = 8'h21;
    localparam logic [7:0] CHAR_COLON     = 8'h3A;
    localparam logic [7:0] CHAR_LOWER_A   = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z   = 8'h7A;
    localparam logic [7:0] CASE_OFFSET    = 8'h20;

    // Configuration register indexes.
    localparam logic [2:0] REG_PATTERN_LENGTH = 3'd0;
    localparam logic [2:0] REG_FOLD_CASE      = 3'd1;
    localparam logic [2:0] REG_WHOLE_WORD     = 3'd2;
    localparam logic [2:0] REG_PATTERN_A      = 3'd3;
    localparam logic [2:0] REG_PATTERN_B      = 3'd4;
    localparam logic [2:0] REG_PATTERN_C      = 3'd5;
    localparam logic [2:0] REG_PATTERN_D      = 3'd6;

    localparam int PATTERN_BITS = 256;

    // Per-text flags carried between bytes.
    typedef struct packed {
        logic prev_boundary;
        logic ended_before;
        logic found_so_far;
    } flags_t;

    function automatic logic is_delim(input logic [7:0] c);
        return (c == CHAR_SPACE) || (c == CHAR_PERIOD) || (c == CHAR_COMMA) ||
               (c == CHAR_SEMICOLON) || (c == CHAR_QUESTION) ||
               (c == CHAR_EXCLAIM) || (c == CHAR_COLON);
    endfunction

    function automatic logic [7:0] upper_ascii(input logic [7:0] c);
        return ((c >= CHAR_LOWER_A) && (c <= CHAR_LOWER_Z)) ? (c - CASE_OFFSET) : c;
    endfunction

endpackage

FILE: rtl/core/word_boundary_substring_matcher.sv
// Top level of the streaming word-boundary substring matcher.
`timescale 1ns / 1ps
// Usage:
// Text bytes enter on the input channel (in_valid, in_stall, text_byte, last_byte);
// each accepted transaction carries one byte, and last_byte marks the end of a text.
// One result transaction (found) leaves on the output channel (out_valid,
// out_stall, found) for every text, after its last byte.
// The configuration port (cfg_we, cfg_index, cfg_data) writes one register per
// cycle: 0 pattern_length, 1 fold_case, 2 whole_word, 3 to 6 the pattern words.
// Writes take effect for the next byte processed; indexes beyond 6 are ignored.
// A byte is captured in an input register and then processed by a single shift-and
// step, and the step's found for a last byte is held in the result register.
// One byte is accepted every cycle, including while a result waits.
// Only a last byte that finds the result register still occupied and stalled
// holds the input register, which raises in_stall until the result is taken.
// Reset loads the register reset values (length one, exact, substring mode,
// zero pattern) and clears the per-text state and both valid flags. After
// every last byte the per-text state returns to its start values.

`include "assert_macros.svh"

module word_boundary_substring_matcher #(
    parameter int PATTERN_MAX = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  text_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        found
);

    localparam logic [5:0] MAX_LEN = 6'(PATTERN_MAX);

    localparam wbsm_pkg::flags_t FLAGS_START = '{prev_boundary: 1'b1,
                                                 ended_before:  1'b0,
                                                 found_so_far:  1'b0};

    // Configuration registers.
    logic [5:0]       pattern_length_reg;
    logic             fold_case_reg;
    logic             whole_word_reg;
    logic [3:0][63:0] pattern_reg;

    // Input register.
    logic       s1_valid_reg;
    logic [7:0] s1_byte_reg;
    logic       s1_last_reg;

    // Per-text state.
    logic [PATTERN_MAX-1:0] partial_reg;
    wbsm_pkg::flags_t       flags_reg;

    // Result register.
    logic out_valid_reg;
    logic found_reg;

    logic                   in_accept;
    logic                   s1_move;
    logic                   s1_fire;
    logic [5:0]             len_m1;
    logic [PATTERN_MAX-1:0] partial_next;
    wbsm_pkg::flags_t       flags_next;
    logic                   found_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_length_reg <= 6'd1;
            fold_case_reg      <= 1'b0;
            whole_word_reg     <= 1'b0;
            pattern_reg        <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                wbsm_pkg::REG_PATTERN_LENGTH: pattern_length_reg <= cfg_data[5:0];
                wbsm_pkg::REG_FOLD_CASE:      fold_case_reg      <= cfg_data[0];
                wbsm_pkg::REG_WHOLE_WORD:     whole_word_reg     <= cfg_data[0];
                wbsm_pkg::REG_PATTERN_A:      pattern_reg[0]     <= cfg_data;
                wbsm_pkg::REG_PATTERN_B:      pattern_reg[1]     <= cfg_data;
                wbsm_pkg::REG_PATTERN_C:      pattern_reg[2]     <= cfg_data;
                wbsm_pkg::REG_PATTERN_D:      pattern_reg[3]     <= cfg_data;
                default:                      ;
            endcase
        end
    end

    // A zero length acts as one; lengths past the pattern storage saturate.
    always_comb
    begin
        if (pattern_length_reg == 6'd0)
        begin
            len_m1 = 6'd0;
        end
        else if (pattern_length_reg > MAX_LEN)
        begin
            len_m1 = MAX_LEN - 6'd1;
        end
        else
        begin
            len_m1 = pattern_length_reg - 6'd1;
        end
    end

    // Only a last byte needs the result register; other bytes always move on.
    assign s1_move   = !s1_last_reg || !out_valid_reg || !out_stall;
    assign s1_fire   = s1_valid_reg && s1_move;
    assign in_stall  = s1_valid_reg && !s1_move;
    assign in_accept = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_byte_reg <= text_byte;
            s1_last_reg <= last_byte;
        end
    end

    wbsm_step #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_step (
        .pattern_flat (pattern_reg),
        .len_m1       (len_m1),
        .fold_case    (fold_case_reg),
        .whole_word   (whole_word_reg),
        .text_byte    (s1_byte_reg),
        .last_byte    (s1_last_reg),
        .partial_in   (partial_reg),
        .flags_in     (flags_reg),
        .partial_out  (partial_next),
        .flags_out    (flags_next),
        .found_out    (found_next)
    );

    // The text state restarts after its last byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_reg <= '0;
            flags_reg   <= FLAGS_START;
        end
        else if (s1_fire)
        begin
            if (s1_last_reg)
            begin
                partial_reg <= '0;
                flags_reg   <= FLAGS_START;
            end
            else
            begin
                partial_reg <= partial_next;
                flags_reg   <= flags_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_fire && s1_last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && s1_last_reg)
        begin
            found_reg <= found_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign found     = found_reg;

    // The input side only waits behind a finished text whose result is blocked.
    `WBSM_ASSERT(a_stall_cause, in_stall |-> (s1_valid_reg && s1_last_reg && out_valid_reg),
                 "input stalled without a blocked result")
    // A processed last byte leaves the text state at its start values.
    `WBSM_ASSERT(a_text_restart, (s1_fire && s1_last_reg) |=>
                 ((partial_reg == '0) && (flags_reg == FLAGS_START)),
                 "text state not restarted after last byte")
    // A new result appears only for a last byte processed in the cycle before.
    `WBSM_ASSERT(a_result_source, $rose(out_valid_reg) |-> $past(s1_fire && s1_last_reg),
                 "result raised without a last byte")
    // During and after reset a stall is never raised while the input register is empty.
    `WBSM_ASSERT_ALWAYS(a_stall_needs_item, !(in_stall && !s1_valid_reg),
                        "stall raised with an empty input register")

endmodule

FILE: rtl/core/wbsm_step.sv
// Shift-and update for one text byte: compare vector, partial matches and hit.
`timescale 1ns / 1ps

module wbsm_step #(
    parameter int PATTERN_MAX = 32
) (
    input  logic [wbsm_pkg::PATTERN_BITS-1:0] pattern_flat,
    input  logic [5:0]                        len_m1,
    input  logic                              fold_case,
    input  logic                              whole_word,
    input  logic [7:0]                        text_byte,
    input  logic                              last_byte,
    input  logic [PATTERN_MAX-1:0]            partial_in,
    input  wbsm_pkg::flags_t                  flags_in,
    output logic [PATTERN_MAX-1:0]            partial_out,
    output wbsm_pkg::flags_t                  flags_out,
    output logic                              found_out
);

    logic [PATTERN_MAX-1:0] eq;
    logic [PATTERN_MAX-1:0] shifted;
    logic [7:0]             text_cmp;
    logic [7:0]             pat_cmp;
    logic                   full;
    logic                   delim;
    logic                   hit;

    assign text_cmp = fold_case ? wbsm_pkg::upper_ascii(text_byte) : text_byte;
    assign delim    = wbsm_pkg::is_delim(text_byte);

    // One compare per pattern position; positions past the length never match.
    always_comb
    begin
        pat_cmp = '0;
        eq      = '0;
        for (int i = 0; i < PATTERN_MAX; i++)
        begin
            pat_cmp = fold_case ? wbsm_pkg::upper_ascii(pattern_flat[i*8 +: 8])
                                : pattern_flat[i*8 +: 8];
            eq[i] = (6'(i) <= len_m1) && (pat_cmp == text_cmp);
        end
    end

    always_comb
    begin
        shifted    = partial_in << 1;
        shifted[0] = !whole_word || flags_in.prev_boundary;
    end

    assign partial_out = shifted & eq;

    always_comb
    begin
        full = 1'b0;
        for (int i = 0; i < PATTERN_MAX; i++)
        begin
            if (len_m1 == 6'(i))
            begin
                full = partial_out[i];
            end
        end
    end

    assign hit = whole_word ? ((flags_in.ended_before && delim) || (last_byte && full))
                            : full;

    assign flags_out.prev_boundary = delim;
    assign flags_out.ended_before  = full;
    assign flags_out.found_so_far  = flags_in.found_so_far || hit;
    assign found_out               = flags_in.found_so_far || hit;

endmodule
